@@ src/zbdt_pkg.sv @@
package zbdt_pkg;

  // Configuration register indexes, in the order of the register list.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_ANGLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd5;

  // Register widths.
  localparam int HAT_W   = 18;
  localparam int SCALE_W = 28;
  localparam int CTR_W   = 26;
  localparam int SCR_W   = 11;

  // Register reset values.
  localparam logic [HAT_W-1:0]   HAT_RESET   = 18'd37837;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 28'd34053489;
  localparam logic [CTR_W-1:0]   CTR_RESET   = 26'd33554432;
  localparam logic [SCR_W-1:0]   SCR_RESET   = 11'd1024;

  // Field widths.
  localparam int COORD_W = 32;
  localparam int DEPTH_W = 31;
  localparam int PIX_W   = 10;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 56;

  // Depth store entries.
  localparam int STORE_W = 32;
  localparam logic [STORE_W-1:0] FAR_DEPTH = 32'hFFFF_FFFF;

endpackage

@@ src/zbuffer_point_depth_test_top.sv @@
// Point depth test against a depth store, with perspective projection.
// Input channel s_*: one transfer per point or clear command. s_tuser is the
// operation (0 test and plot, 1 clear the store); s_tdata carries x, y, z in
// signed fixed point. Output channel m_*: exactly one result transfer per
// input transfer, in order. m_tuser is the written flag; m_tdata carries the
// pixel and the stored depth, all zero when nothing was written.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, which the block itself does not enforce. A point
// passes from its transfer to its result through a multiply state, a sum
// state, a shared restoring divider producing one quotient bit per cycle for
// both screen axes, a read state and a compare/write state of the depth
// memory. Points are taken one at a time; the next is accepted once the
// result is loaded into the output register, even while that result still
// waits. A clear command sweeps the memory one entry per cycle, then returns
// its result. After reset the same sweep runs without a result, and no input
// is accepted until it ends. When the receiver stalls, the block holds its
// finished result and waits. Points that fail a check skip to their result.
module zbuffer_point_depth_test_top #(
  parameter int BUFFER_SIDE   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // point_x [31:0], point_y [63:32], point_z [95:64]
  input  logic [zbdt_pkg::IN_DATA_W-1:0]      s_tdata,
  // operation
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // pixel_x [9:0], pixel_y [19:10], stored_depth [50:20], zeros above
  output logic [zbdt_pkg::OUT_DATA_W-1:0]     m_tdata,
  // written
  output logic                                m_tuser,
  input  logic                                cfg_we,
  input  logic [zbdt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [zbdt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import zbdt_pkg::*;

  localparam int STORE_SIZE = BUFFER_SIDE * BUFFER_SIDE;
  localparam int ADDR_W = $clog2(STORE_SIZE);
  localparam int QB     = $clog2(BUFFER_SIDE);
  localparam int CNT_W  = $clog2(QB + 1);
  localparam int BND_W  = HAT_W + DEPTH_W;
  localparam int AX_W   = SCALE_W + 1 + COORD_W;
  localparam int BZ_W   = CTR_W + DEPTH_W;
  localparam int NUM_W  = AX_W + 1;
  localparam int REM_W  = NUM_W - 1;
  localparam int SH_W   = DEPTH_W + FRACTION_BITS + QB;
  localparam int CMP_W  = (REM_W > SH_W) ? REM_W : SH_W;
  localparam int XS_W   = ((COORD_W + FRACTION_BITS > BND_W) ?
                           COORD_W + FRACTION_BITS : BND_W) + 1;
  localparam int LIM_W  = (QB + 1 > SCR_W) ? QB + 1 : SCR_W;
  localparam int PAD_W  = OUT_DATA_W - 2 * PIX_W - DEPTH_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // Configuration registers.
  logic [HAT_W-1:0]   hat;
  logic [SCALE_W-1:0] scale;
  logic [CTR_W-1:0]   ctr_x;
  logic [CTR_W-1:0]   ctr_y;
  logic [SCR_W-1:0]   scr_w;
  logic [SCR_W-1:0]   scr_h;

  // Control and datapath registers.
  logic [2:0]                 state;
  logic [ADDR_W-1:0]          clr_addr;
  logic                       clr_reply;
  logic [CNT_W-1:0]           cnt;
  logic signed [COORD_W-1:0]  x_r;
  logic signed [COORD_W-1:0]  y_r;
  logic [DEPTH_W-1:0]         z_r;
  logic [BND_W-1:0]           bound;
  logic signed [AX_W-1:0]     ax;
  logic signed [AX_W-1:0]     ay;
  logic [BZ_W-1:0]            bz;
  logic [BZ_W-1:0]            cz;
  logic [REM_W-1:0]           rx;
  logic [REM_W-1:0]           ry;
  logic [SH_W-1:0]            dsh;
  logic [QB:0]                qx;
  logic [QB:0]                qy;
  logic [ADDR_W-1:0]          addr;
  logic                       res_hit;
  logic [STORE_W-1:0]         rd_data;

  // Depth store.
  logic [STORE_W-1:0] store [STORE_SIZE];
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [STORE_W-1:0] wr_data;

  // Combinational helpers.
  logic signed [NUM_W-1:0] sum_x;
  logic signed [NUM_W-1:0] sum_y;
  logic signed [XS_W-1:0]  xs;
  logic signed [XS_W-1:0]  ys;
  logic signed [XS_W-1:0]  bnd;
  logic                    clip_ok;
  logic                    ge_x;
  logic                    ge_y;
  logic [LIM_W-1:0]        wlim;
  logic [LIM_W-1:0]        hlim;
  logic                    pix_ok;
  logic [ADDR_W-1:0]       addr_calc;
  logic                    in_xfer;
  logic                    out_free;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Clip test and projection numerators.
  always_comb begin
    sum_x   = NUM_W'(ax) + $signed(NUM_W'(bz));
    sum_y   = NUM_W'(ay) + $signed(NUM_W'(cz));
    xs      = XS_W'(x_r) <<< FRACTION_BITS;
    ys      = XS_W'(y_r) <<< FRACTION_BITS;
    bnd     = $signed(XS_W'(bound));
    clip_ok = (xs < bnd) && (xs > -bnd) && (ys < bnd) && (ys > -bnd) &&
              !sum_x[NUM_W-1] && !sum_y[NUM_W-1];
  end

  // One restoring division step per cycle for both axes.
  assign ge_x = CMP_W'(rx) >= CMP_W'(dsh);
  assign ge_y = CMP_W'(ry) >= CMP_W'(dsh);

  // Screen limits clamped to the store side, and the store address.
  always_comb begin
    wlim = (LIM_W'(scr_w) > LIM_W'(BUFFER_SIDE)) ? LIM_W'(BUFFER_SIDE) : LIM_W'(scr_w);
    hlim = (LIM_W'(scr_h) > LIM_W'(BUFFER_SIDE)) ? LIM_W'(BUFFER_SIDE) : LIM_W'(scr_h);
    pix_ok = (LIM_W'(qx) < wlim) && (LIM_W'(qy) < hlim);
    addr_calc = ADDR_W'(qx[QB-1:0]) * ADDR_W'(BUFFER_SIDE) + ADDR_W'(qy[QB-1:0]);
  end

  // Memory write port: clearing sweep or depth update.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr;
    wr_data = STORE_W'(z_r);
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = FAR_DEPTH;
    end else if (state == S_CMP && STORE_W'(z_r) < rd_data) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_data <= store[addr_calc];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      hat   <= HAT_RESET;
      scale <= SCALE_RESET;
      ctr_x <= CTR_RESET;
      ctr_y <= CTR_RESET;
      scr_w <= SCR_RESET;
      scr_h <= SCR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_ANGLE: hat   <= cfg_data[HAT_W-1:0];
        REG_SCALE:      scale <= cfg_data[SCALE_W-1:0];
        REG_CENTER_X:   ctr_x <= cfg_data[CTR_W-1:0];
        REG_CENTER_Y:   ctr_y <= cfg_data[CTR_W-1:0];
        REG_WIDTH:      scr_w <= cfg_data[SCR_W-1:0];
        REG_HEIGHT:     scr_h <= cfg_data[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers, loaded by the sequencer state.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        x_r <= s_tdata[COORD_W-1:0];
        y_r <= s_tdata[2*COORD_W-1:COORD_W];
        z_r <= s_tdata[2*COORD_W+DEPTH_W-1:2*COORD_W];
      end
      S_MUL: begin
        bound <= hat * z_r;
        ax    <= $signed({1'b0, scale}) * x_r;
        ay    <= $signed({1'b0, scale}) * y_r;
        bz    <= ctr_x * z_r;
        cz    <= ctr_y * z_r;
      end
      S_SUM: begin
        rx  <= sum_x[REM_W-1:0];
        ry  <= sum_y[REM_W-1:0];
        dsh <= {z_r, {(FRACTION_BITS + QB){1'b0}}};
        qx  <= '0;
        qy  <= '0;
      end
      S_DIV: begin
        rx  <= ge_x ? REM_W'(CMP_W'(rx) - CMP_W'(dsh)) : rx;
        ry  <= ge_y ? REM_W'(CMP_W'(ry) - CMP_W'(dsh)) : ry;
        qx  <= {qx[QB-1:0], ge_x};
        qy  <= {qy[QB-1:0], ge_y};
        dsh <= dsh >> 1;
      end
      S_CHK: begin
        addr <= addr_calc;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      cnt       <= '0;
      res_hit   <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(STORE_SIZE - 1)) begin
            clr_addr <= '0;
            res_hit  <= 1'b0;
            state    <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            res_hit <= 1'b0;
            if (s_tuser) begin
              clr_reply <= 1'b1;
              state     <= S_CLEAR;
            end else if (s_tdata[IN_DATA_W-1] ||
                         s_tdata[IN_DATA_W-1:2*COORD_W] == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          cnt   <= CNT_W'(QB);
          state <= clip_ok ? S_DIV : S_DONE;
        end
        S_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          state <= pix_ok ? S_CMP : S_DONE;
        end
        S_CMP: begin
          res_hit <= STORE_W'(z_r) < rd_data;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tuser <= res_hit;
      m_tdata <= res_hit ? {{PAD_W{1'b0}}, z_r, PIX_W'(qy[QB-1:0]), PIX_W'(qx[QB-1:0])}
                         : '0;
    end
  end

  // Checks on the sequencer and the result register.
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("input accepted during the clearing sweep");

  a_cmp_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |=> (state == S_DONE))
    else $error("depth compare not followed by the result state");

  a_hit_depth: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[2*PIX_W+DEPTH_W-1:2*PIX_W] != '0))
    else $error("written result with zero depth");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("rejected result carries data");

endmodule
